// ===== hw/rtl/tk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tk_pkg
// Shared constants and result type for the top-k score ranker.
// ----------------------------------------------------------------------------
package tk_pkg;

    localparam int MAX_RESULTS = 10;
    localparam int RANK_W      = 4;
    localparam int DOC_W       = 10;
    localparam int SCORE_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [RANK_W-1:0]  rank_position;
        logic [DOC_W-1:0]   doc_number;
        logic [SCORE_W-1:0] doc_score;
        logic               overflowed;
        logic               last_of_run;
    } tk_result_t;

endpackage

// ===== hw/rtl/tk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tk_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tk_fifo
// Short register queue carrying ranking jobs from front to back.
// ----------------------------------------------------------------------------
module tk_fifo
    import tk_pkg::*;
#(
    parameter int WIDTH = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNTW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tk_front
// Load side: stores incoming scores, counts the set, flags drops and
// queues a ranking job on the last item.
// ----------------------------------------------------------------------------
module tk_front
    import tk_pkg::*;
#(
    parameter int MAX_DOCS   = 1024,
    parameter int SCORE_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  logic [SCORE_W-1:0]                            s_axis_tdata,
    input  logic                                          s_axis_tlast,
    output logic                                          wr_en,
    output logic [(MAX_DOCS > 1 ? $clog2(MAX_DOCS) : 1)-1:0] wr_addr,
    output logic [(SCORE_BITS < SCORE_W ? SCORE_BITS : SCORE_W)-1:0] wr_data,
    output logic                                          job_push,
    output logic [$clog2(MAX_DOCS + 1):0]                 job_data,
    input  logic                                          job_full,
    input  logic                                          rank_done
);

    localparam int AW      = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int CW      = $clog2(MAX_DOCS + 1);
    localparam int STORE_W = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg;
    logic          accept, has_room;

    assign s_axis_tready = !busy_reg && !job_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign has_room      = (32'(cnt_reg) < MAX_DOCS);

    assign wr_en   = accept && has_room;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = s_axis_tdata[STORE_W-1:0];

    assign cnt_next = has_room ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_next = ovf_reg || !has_room;

    assign job_push = accept && s_axis_tlast;
    assign job_data = {ovf_next, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_axis_tlast) begin
                    cnt_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end else if (rank_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/tk_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tk_back
// Ranking side: for each rank, scans the stored set for the largest
// (score, doc) key below the previous pick and emits it.
// ----------------------------------------------------------------------------
module tk_back
    import tk_pkg::*;
#(
    parameter int MAX_DOCS   = 1024,
    parameter int TOP_K      = 10,
    parameter int SCORE_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          job_valid,
    input  logic [$clog2(MAX_DOCS + 1):0]                 job_data,
    output logic                                          job_pop,
    output logic                                          rd_en,
    output logic [(MAX_DOCS > 1 ? $clog2(MAX_DOCS) : 1)-1:0] rd_addr,
    input  logic [(SCORE_BITS < SCORE_W ? SCORE_BITS : SCORE_W)-1:0] rd_data,
    output logic                                          rank_done,
    output logic                                          res_valid,
    input  logic                                          res_ready,
    output tk_result_t                                    res
);

    localparam int AW      = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int CW      = $clog2(MAX_DOCS + 1);
    localparam int STORE_W = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;
    localparam int KLIM    = (TOP_K < MAX_RESULTS) ? TOP_K : MAX_RESULTS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      n_reg;
    logic               ovf_reg;
    logic [RANK_W-1:0]  k_reg, r_reg;
    logic [AW-1:0]      addr_reg, last_addr;
    logic               rd_valid_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               found_reg, have_prev_reg;
    logic [STORE_W-1:0] best_s_reg, prev_s_reg;
    logic [AW-1:0]      best_idx_reg, prev_idx_reg;
    logic               done_reg;
    logic               out_valid_reg;
    tk_result_t         out_reg;

    logic [CW-1:0]          job_cnt;
    logic [RANK_W-1:0]      job_k;
    logic                   eligible, take;
    logic                   slot_free;
    logic [DOC_W+AW-1:0]    doc_ext;
    logic [SCORE_W+STORE_W-1:0] score_ext;

    assign job_cnt = job_data[CW-1:0];
    assign job_k   = (32'(job_cnt) < KLIM) ? RANK_W'(job_cnt) : RANK_W'(KLIM);
    assign job_pop = (state_reg == S_IDLE) && job_valid;

    assign last_addr = AW'(n_reg - 1'b1);
    assign rd_en     = (state_reg == S_SCAN);
    assign rd_addr   = addr_reg;

    // keys are unique since doc numbers are; strictly below previous pick
    assign eligible = !have_prev_reg || (rd_data < prev_s_reg) ||
                      ((rd_data == prev_s_reg) && (rd_idx_reg < prev_idx_reg));
    // later docs arrive later, so >= on score gives the higher doc on ties
    assign take = rd_valid_reg && eligible && (!found_reg || rd_data >= best_s_reg);

    assign slot_free = !out_valid_reg || res_ready;
    assign doc_ext   = {{DOC_W{1'b0}}, best_idx_reg};
    assign score_ext = {{SCORE_W{1'b0}}, best_s_reg};

    assign rank_done = done_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (res_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (take) begin
                found_reg    <= 1'b1;
                best_s_reg   <= rd_data;
                best_idx_reg <= rd_idx_reg;
            end

            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        n_reg         <= job_cnt;
                        ovf_reg       <= job_data[CW];
                        k_reg         <= job_k;
                        r_reg         <= '0;
                        addr_reg      <= '0;
                        found_reg     <= 1'b0;
                        have_prev_reg <= 1'b0;
                        if (job_k == '0) begin
                            done_reg <= 1'b1;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    rd_valid_reg <= 1'b1;
                    rd_idx_reg   <= addr_reg;
                    if (addr_reg == last_addr) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    rd_valid_reg <= 1'b0;
                    state_reg    <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        out_valid_reg          <= 1'b1;
                        out_reg.rank_position  <= r_reg;
                        out_reg.doc_number     <= doc_ext[DOC_W-1:0];
                        out_reg.doc_score      <= score_ext[SCORE_W-1:0];
                        out_reg.overflowed     <= ovf_reg;
                        out_reg.last_of_run    <= (r_reg == k_reg - 1'b1);
                        prev_s_reg             <= best_s_reg;
                        prev_idx_reg           <= best_idx_reg;
                        have_prev_reg          <= 1'b1;
                        found_reg              <= 1'b0;
                        r_reg                  <= r_reg + 1'b1;
                        addr_reg               <= '0;
                        if (r_reg == k_reg - 1'b1) begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/top_k_score_ranker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_ranker
// Loads per-document scores, then emits the top K documents by score.
// ----------------------------------------------------------------------------
// Load: one score per cycle into the score RAM while s_axis_tready is high.
// Ranking: after the last item, each rank scans the N stored docs with one RAM
//   read per doc, waits out the read latency, then emits its pick, waiting
//   while the output stalls. The input stalls from the last item until the
//   cycle after the final result is registered.
// Reset: synchronous, active low; clears counters, flags, queue and control.
//   The score RAM is not cleared; no clearing pass is run.
// ----------------------------------------------------------------------------
module top_k_score_ranker
    import tk_pkg::*;
#(
    parameter int MAX_DOCS   = 1024,
    parameter int TOP_K      = 10,
    parameter int SCORE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] score
    input  logic        s_axis_tlast,   // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] rank_position, [13:4] doc_number,
                                        // [29:14] doc_score, [31:30] zero
    output logic        m_axis_tuser,   // overflowed
    output logic        m_axis_tlast    // last_of_run
);

    localparam int AW      = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int CW      = $clog2(MAX_DOCS + 1);
    localparam int STORE_W = (SCORE_BITS < SCORE_W) ? SCORE_BITS : SCORE_W;

    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [STORE_W-1:0] wr_data, rd_data;
    logic               job_push, job_full, job_pop, job_valid;
    logic [CW:0]        job_in, job_out;
    logic               rank_done;
    tk_result_t         res;

    tk_front #(
        .MAX_DOCS   (MAX_DOCS),
        .SCORE_BITS (SCORE_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_push      (job_push),
        .job_data      (job_in),
        .job_full      (job_full),
        .rank_done     (rank_done)
    );

    tk_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_DOCS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tk_fifo #(
        .WIDTH (CW + 1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_out)
    );

    tk_back #(
        .MAX_DOCS   (MAX_DOCS),
        .TOP_K      (TOP_K),
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rank_done (rank_done),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {2'b00, res.doc_score, res.doc_number, res.rank_position};
    assign m_axis_tuser = res.overflowed;
    assign m_axis_tlast = res.last_of_run;

endmodule
